// ===== rtl/lcs_pkg.sv =====
// package: shared types and constants for the lcs block
package lcs_pkg;
   localparam int MaxLenDefault = 64;
   localparam int LenW = 7;
   localparam int SymW = 8;
   localparam int KindW = 2;

   typedef enum logic [KindW-1:0] {
      KIND_FIRST   = 2'd0,
      KIND_SECOND  = 2'd1,
      KIND_COMPUTE = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_TB_START,
      ST_TB_RD,
      ST_TB_DEC,
      ST_EMIT,
      ST_EMIT_WAIT
   } state_type;
endpackage

// ===== rtl/lcs_length_and_traceback_top.sv =====
// top level: lcs score table fill, traceback and result emission
// a load is written to its store on accept; a compute transaction fills the table,
//   traces back from the corner, then emits one result a cycle while rsp_stall is low
// throughput: one load transaction per cycle while idle; one compute run at a time
// the fill rate is set by the single score memory port pair (three reads then a write per cell)
// reset: synchronous active high, clears counts and control; memories stay undefined
module lcs_length_and_traceback_top #(
   parameter int MAX_LEN = lcs_pkg::MaxLenDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [lcs_pkg::KindW-1:0] req_kind,
   input  logic [lcs_pkg::SymW-1:0]  req_symbol,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [lcs_pkg::LenW-1:0]  rsp_lcs_length,
   output logic [lcs_pkg::SymW-1:0]  rsp_out_symbol,
   output logic                      rsp_is_empty,
   output logic                      rsp_last
);
   import lcs_pkg::*;

   localparam int IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int Dim = MAX_LEN + 1;
   localparam int AddrW = $clog2(Dim * Dim);

   // sequence and answer stores
   logic [SymW-1:0] first_mem [MAX_LEN];
   logic [SymW-1:0] second_mem [MAX_LEN];
   logic [SymW-1:0] answer_mem [MAX_LEN];
   // score table, border handled by logic, never stored as zero writes
   logic [LenW-1:0] score_mem [Dim*Dim];

   state_type state_ff, state_in;
   logic [LenW-1:0] n1_ff, n1_in, n2_ff, n2_in;
   logic [LenW-1:0] r_ff, r_in, c_ff, c_in;
   logic [LenW-1:0] len_ff, len_in, pos_ff, pos_in, k_ff, k_in;
   logic [LenW-1:0] rd_diag_ff, rd_up_ff;
   logic [SymW-1:0] a_ff, b_ff, ans_rd_ff;
   logic [1:0]      phase_ff, phase_in;

   logic accept;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;

   // store writes
   always_ff @(posedge clock) begin
      if (accept && kind_type'(req_kind) == KIND_FIRST && n1_ff < LenW'(MAX_LEN))
         first_mem[n1_ff[IdxW-1:0]] <= req_symbol;
      if (accept && kind_type'(req_kind) == KIND_SECOND && n2_ff < LenW'(MAX_LEN))
         second_mem[n2_ff[IdxW-1:0]] <= req_symbol;
   end

   // score address helper
   function automatic logic [AddrW-1:0] addr(input logic [LenW-1:0] r,
                                             input logic [LenW-1:0] c);
      logic [AddrW+LenW-1:0] p;
      p = (AddrW+LenW)'(r) * (AddrW+LenW)'(Dim) + (AddrW+LenW)'(c);
      return p[AddrW-1:0];
   endfunction

   // sequence symbol reads, registered; r/c are 1-based so index r-1
   logic [LenW-1:0] rm1, cm1;
   assign rm1 = r_ff - 1'b1;
   assign cm1 = c_ff - 1'b1;
   always_ff @(posedge clock) begin
      a_ff <= first_mem[rm1[IdxW-1:0]];
      b_ff <= second_mem[cm1[IdxW-1:0]];
   end

   // score reads: neighbors over phases on one read port, corner at traceback start
   logic [AddrW-1:0] rd_addr;
   logic [LenW-1:0]  rd_data_ff;
   logic             rd_border;
   logic [LenW-1:0]  rd_r, rd_c;
   always_comb begin
      rd_r = r_ff;
      rd_c = c_ff;
      case (phase_ff)
         2'd0: begin rd_r = rm1; rd_c = cm1; end
         2'd1: begin rd_r = rm1; rd_c = c_ff; end
         2'd2: begin rd_r = r_ff; rd_c = cm1; end
         default: begin rd_r = r_ff; rd_c = c_ff; end
      endcase
      if (state_ff == ST_TB_START) begin
         rd_r = n1_ff;
         rd_c = n2_ff;
      end
   end
   assign rd_addr = addr(rd_r, rd_c);
   logic border_ff;
   always_ff @(posedge clock) begin
      rd_data_ff <= score_mem[rd_addr];
      border_ff  <= (rd_r == '0) || (rd_c == '0);
   end
   assign rd_border = border_ff;
   logic [LenW-1:0] rd_val;
   assign rd_val = rd_border ? '0 : rd_data_ff;

   // cell value
   logic [LenW-1:0] cell_v;
   logic [LenW-1:0] diag_v, up_v, left_v;
   assign diag_v = rd_diag_ff;
   assign up_v   = rd_up_ff;
   assign left_v = rd_val;
   always_comb begin
      if (a_ff == b_ff) cell_v = diag_v + 1'b1;
      else cell_v = (up_v > left_v) ? up_v : left_v;
   end

   logic score_we;
   assign score_we = (state_ff == ST_FILL_WR);
   always_ff @(posedge clock) begin
      if (score_we) score_mem[addr(r_ff, c_ff)] <= cell_v;
   end

   logic ans_we;
   assign ans_we = (state_ff == ST_TB_DEC) && (a_ff == b_ff) && (pos_ff != '0);
   always_ff @(posedge clock) begin
      if (ans_we) answer_mem[pos_in[IdxW-1:0]] <= a_ff;
      ans_rd_ff <= answer_mem[k_in[IdxW-1:0]];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (accept && kind_type'(req_kind) == KIND_COMPUTE) begin
               if (n1_ff == '0 || n2_ff == '0) state_in = ST_TB_START;
               else state_in = ST_FILL_RD;
            end
         ST_FILL_RD: if (phase_ff == 2'd2) state_in = ST_FILL_WR;
         ST_FILL_WR:
            if (r_ff == n1_ff && c_ff == n2_ff) state_in = ST_TB_START;
            else state_in = ST_FILL_RD;
         ST_TB_START: state_in = ST_TB_RD;
         ST_TB_RD:
            if (r_ff == '0 || c_ff == '0) state_in = ST_EMIT_WAIT;
            else if (phase_ff == 2'd2) state_in = ST_TB_DEC;
         ST_TB_DEC: state_in = ST_TB_RD;
         ST_EMIT_WAIT: state_in = ST_EMIT;
         ST_EMIT:
            if (!rsp_stall && (len_ff == '0 || k_ff + 1'b1 == len_ff)) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      n1_in = n1_ff; n2_in = n2_ff; r_in = r_ff; c_in = c_ff;
      len_in = len_ff; pos_in = pos_ff; k_in = k_ff; phase_in = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            k_in = '0;
            if (accept) begin
               case (kind_type'(req_kind))
                  KIND_FIRST:  if (n1_ff < LenW'(MAX_LEN)) n1_in = n1_ff + 1'b1;
                  KIND_SECOND: if (n2_ff < LenW'(MAX_LEN)) n2_in = n2_ff + 1'b1;
                  KIND_COMPUTE: begin
                     r_in = 7'd1; c_in = 7'd1; phase_in = 2'd0;
                     if (n1_ff == '0 || n2_ff == '0) begin
                        r_in = n1_ff; c_in = n2_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL_RD: phase_in = phase_ff + 1'b1;
         ST_FILL_WR: begin
            phase_in = 2'd0;
            if (c_ff == n2_ff) begin c_in = 7'd1; r_in = r_ff + 1'b1; end
            else c_in = c_ff + 1'b1;
         end
         ST_TB_START: begin
            r_in = n1_ff; c_in = n2_ff; phase_in = 2'd1;
            len_in = '0; pos_in = '0;
         end
         // phase 1 reads up, phase 2 reads left
         ST_TB_RD: phase_in = 2'd2;
         ST_TB_DEC: begin
            phase_in = 2'd1;
            if (a_ff == b_ff) begin
               if (pos_ff != '0) pos_in = pos_ff - 1'b1;
               r_in = rm1; c_in = cm1;
            end else if (up_v > left_v) r_in = rm1;
            else c_in = cm1;
         end
         ST_EMIT_WAIT: k_in = '0;
         ST_EMIT:
            if (!rsp_stall) begin
               k_in = k_ff + 1'b1;
               if (state_in == ST_IDLE) begin n1_in = '0; n2_in = '0; end
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n1_ff <= '0; n2_ff <= '0; phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         n1_ff <= n1_in; n2_ff <= n2_in; phase_ff <= phase_in;
      end
      r_ff <= r_in; c_ff <= c_in; k_ff <= k_in;
      // capture reads by phase of the previous cycle
      if (state_ff == ST_FILL_RD || state_ff == ST_TB_RD) begin
         case (phase_ff)
            2'd1: rd_diag_ff <= rd_val;
            2'd2: rd_up_ff <= rd_val;
            default: ;
         endcase
      end
   end

   // length and answer pointer: first current read of traceback is the corner
   logic first_rd_ff;
   always_ff @(posedge clock) begin
      if (reset) first_rd_ff <= 1'b0;
      else first_rd_ff <= (state_ff == ST_TB_START);
      if (state_ff == ST_TB_START) begin
         len_ff <= '0; pos_ff <= '0;
      end else if (first_rd_ff) begin
         len_ff <= rd_val; pos_ff <= rd_val;
      end else begin
         len_ff <= len_in; pos_ff <= pos_in;
      end
   end

   // outputs
   assign rsp_valid      = (state_ff == ST_EMIT);
   assign rsp_lcs_length = len_ff;
   assign rsp_is_empty   = (len_ff == '0);
   assign rsp_out_symbol = (len_ff == '0) ? '0 : ans_rd_ff;
   assign rsp_last       = (len_ff == '0) || (k_ff + 1'b1 == len_ff);

`ifndef SYNTHESIS
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("req taken while busy");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      (n1_ff <= LenW'(MAX_LEN)) && (n2_ff <= LenW'(MAX_LEN))) else $error("count overflow");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (len_ff <= n1_ff) && (len_ff <= n2_ff)) else $error("length too big");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> (n1_ff == '0) && (n2_ff == '0))
      else $error("counts not cleared");
`endif
endmodule
